// ----- design/bank_switch_mapper_with_scanline_irq_assert.svh -----
// Assertion macros for the bank switching mapper.
// Used by the top level; the checks assume a clock named clk and a reset named rst_n.
`ifndef BANK_SWITCH_MAPPER_WITH_SCANLINE_IRQ_ASSERT_SVH
`define BANK_SWITCH_MAPPER_WITH_SCANLINE_IRQ_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication.
`define BSM_CHECK_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define BSM_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BSM_CHECK_IMP(label, ante, cons, msg)
`define BSM_CHECK_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- design/bsm_pkg.sv -----
// Shared types and constants of the bank switching mapper.
// No dependencies; imported by the front end, the queue, the back end and the top level.
`default_nettype none

package bsm_pkg;

    localparam int WORK_RAM_BYTES = 8192;
    localparam int RAM_AW         = $clog2(WORK_RAM_BYTES);
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int BANK_REGS      = 8;

    // Input actions.
    localparam logic [2:0] ACT_CPU_READ  = 3'd0;
    localparam logic [2:0] ACT_CPU_WRITE = 3'd1;
    localparam logic [2:0] ACT_PPU       = 3'd2;
    localparam logic [2:0] ACT_TICK      = 3'd3;
    localparam logic [2:0] ACT_ACK       = 3'd4;

    // Result targets.
    localparam logic [2:0] TGT_PASS = 3'd0;
    localparam logic [2:0] TGT_RAM  = 3'd1;
    localparam logic [2:0] TGT_PRG  = 3'd2;
    localparam logic [2:0] TGT_CHR  = 3'd3;
    localparam logic [2:0] TGT_REG  = 3'd4;

    // Mirroring modes.
    localparam logic [1:0] MIRROR_HARD  = 2'd0;
    localparam logic [1:0] MIRROR_VERT  = 2'd1;
    localparam logic [1:0] MIRROR_HORIZ = 2'd2;

    // Register windows above 0x8000, by address bits 14..13.
    localparam logic [1:0] WIN_SELECT = 2'd0;
    localparam logic [1:0] WIN_MIRROR = 2'd1;
    localparam logic [1:0] WIN_RELOAD = 2'd2;
    localparam logic [1:0] WIN_IRQ_EN = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_LAST_PRG  = 1'b0;
    localparam logic CFG_CHR_COUNT = 1'b1;

    localparam logic [5:0] LAST_PRG_RESET  = 6'd31;
    localparam logic [8:0] CHR_COUNT_RESET = 9'd256;

    typedef enum logic [3:0] {
        KIND_PASS,
        KIND_NOP,
        KIND_RAM_RD,
        KIND_RAM_WR,
        KIND_PRG_RD,
        KIND_REG_WR,
        KIND_CHR,
        KIND_TICK,
        KIND_ACK
    } kind_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] address;
        logic [7:0]  write_data;
    } item_t;

    typedef struct packed {
        logic [2:0]  target;
        logic [18:0] mapped_addr;
        logic        chr_in_range;
        logic [7:0]  read_data;
        logic        irq_line;
        logic [1:0]  mirror_mode;
    } result_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] address;
        logic [7:0]  write_data;
    } entry_t;

endpackage

`default_nettype wire

// ----- design/bsm_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module bsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- design/bsm_front.sv -----
// Front end: takes input beats and classifies them into queue entries.
// Depends on bsm_pkg.
`default_nettype none

module bsm_front (
    input  wire logic           item_valid,
    output logic                item_stall,
    input  wire bsm_pkg::item_t item,
    input  wire logic           queue_full,
    input  wire logic           clearing,
    output logic                push,
    output bsm_pkg::entry_t     entry
);
    import bsm_pkg::*;

    logic in_ram_window;
    logic in_rom_window;
    logic in_chr_window;

    assign item_stall = queue_full || clearing;
    assign push       = item_valid && !item_stall;

    assign in_ram_window = (item.address[15:13] == 3'b011);
    assign in_rom_window = item.address[15];
    assign in_chr_window = (item.address[15:13] == 3'b000);

    always_comb
    begin
        entry.address    = item.address;
        entry.write_data = item.write_data;
        case (item.action)
            ACT_CPU_READ:
            begin
                if (in_ram_window)
                    entry.kind = KIND_RAM_RD;
                else if (in_rom_window)
                    entry.kind = KIND_PRG_RD;
                else
                    entry.kind = KIND_PASS;
            end
            ACT_CPU_WRITE:
            begin
                if (in_ram_window)
                    entry.kind = KIND_RAM_WR;
                else if (in_rom_window)
                    entry.kind = KIND_REG_WR;
                else
                    entry.kind = KIND_PASS;
            end
            ACT_PPU:
            begin
                entry.kind = in_chr_window ? KIND_CHR : KIND_PASS;
            end
            ACT_TICK: entry.kind = KIND_TICK;
            ACT_ACK:  entry.kind = KIND_ACK;
            default:  entry.kind = KIND_NOP;
        endcase
    end

endmodule

`default_nettype wire

// ----- design/bsm_fifo.sv -----
// Short queue of classified entries between the front and back ends.
// Depends on bsm_pkg.
`default_nettype none

module bsm_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire bsm_pkg::entry_t push_entry,
    input  wire logic            pop,
    output bsm_pkg::entry_t      head,
    output logic                 full,
    output logic                 empty
);
    import bsm_pkg::*;

    entry_t             slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

// ----- design/bsm_back.sv -----
// Back end: mapper state, bank translation, IRQ counter and work RAM access.
// Depends on bsm_pkg and bsm_ram.
`default_nettype none

module bsm_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_write_en,
    input  wire logic            cfg_index,
    input  wire logic [8:0]      cfg_data,
    input  wire bsm_pkg::entry_t entry,
    input  wire logic            queue_empty,
    output logic                 pop,
    output logic                 clearing,
    output logic                 result_valid,
    input  wire logic            result_stall,
    output bsm_pkg::result_t     result
);
    import bsm_pkg::*;

    // Configuration.
    logic [5:0] last_prg_reg;
    logic [8:0] chr_count_reg;

    // Mapper state.
    logic [7:0] bank_select_reg;
    logic [7:0] bank_select_next;
    logic [7:0] bank_regs_reg  [BANK_REGS];
    logic [7:0] bank_regs_next [BANK_REGS];
    logic [1:0] mirror_reg;
    logic [1:0] mirror_next;
    logic [7:0] irq_count_reg;
    logic [7:0] irq_count_next;
    logic [7:0] irq_reload_reg;
    logic [7:0] irq_reload_next;
    logic       irq_enable_reg;
    logic       irq_enable_next;
    logic       irq_flag_reg;
    logic       irq_flag_next;
    logic       reload_req_reg;
    logic       reload_req_next;

    // Clearing pass.
    logic              clearing_reg;
    logic [RAM_AW-1:0] clear_cnt_reg;

    // Execute stage and output register.
    logic    s1_valid_reg;
    logic    s1_ram_rd_reg;
    result_t s1_res_reg;
    result_t s1_out;
    result_t res;
    logic    out_valid_reg;
    result_t out_reg;
    logic    s1_adv;
    logic    issue;

    // Translation helpers.
    logic [5:0]  second_last;
    logic [5:0]  prg_bank;
    logic [12:0] chr_a;
    logic [2:0]  chr_idx;
    logic [7:0]  chr_bank;
    logic [18:0] chr_mapped;
    logic [2:0]  reg_num;
    logic [7:0]  reg_data;

    // Work RAM port.
    logic              ram_en;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_addr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    assign clearing = clearing_reg;
    assign s1_adv   = !out_valid_reg || !result_stall;
    assign issue    = !queue_empty && !clearing_reg && (!s1_valid_reg || s1_adv);
    assign pop      = issue;

    assign ram_en    = clearing_reg
                    || (issue && (entry.kind == KIND_RAM_RD || entry.kind == KIND_RAM_WR));
    assign ram_we    = clearing_reg || (issue && entry.kind == KIND_RAM_WR);
    assign ram_addr  = clearing_reg ? clear_cnt_reg : entry.address[RAM_AW-1:0];
    assign ram_wdata = clearing_reg ? 8'd0 : entry.write_data;

    bsm_ram #(
        .WIDTH (8),
        .DEPTH (WORK_RAM_BYTES)
    ) u_work_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Program window bank; the second-to-last bank wraps within six bits.
    assign second_last = last_prg_reg - 6'd1;

    always_comb
    begin
        case (entry.address[14:13])
            2'd0:    prg_bank = bank_select_reg[6] ? second_last : bank_regs_reg[6][5:0];
            2'd1:    prg_bank = bank_regs_reg[7][5:0];
            2'd2:    prg_bank = bank_select_reg[6] ? bank_regs_reg[6][5:0] : second_last;
            default: prg_bank = last_prg_reg;
        endcase
    end

    // Character mode 1 exchanges the two 4 KB halves.
    assign chr_a    = {entry.address[12] ^ bank_select_reg[7], entry.address[11:0]};
    assign chr_idx  = chr_a[12] ? (3'd2 + {1'b0, chr_a[11:10]}) : {2'b00, chr_a[11]};
    assign chr_bank = bank_regs_reg[chr_idx];
    assign chr_mapped = chr_a[12] ? {1'b0, chr_bank, chr_a[9:0]}
                                  : ({1'b0, chr_bank, 10'd0} + {8'd0, chr_a[10:0]});

    assign reg_num = bank_select_reg[2:0];

    always_comb
    begin
        if (reg_num <= 3'd1)
            reg_data = entry.write_data & 8'b1111_1110;
        else if (reg_num >= 3'd6)
            reg_data = entry.write_data & 8'b0011_1111;
        else
            reg_data = entry.write_data;
    end

    // State update for the issued entry.
    always_comb
    begin
        bank_select_next = bank_select_reg;
        bank_regs_next   = bank_regs_reg;
        mirror_next      = mirror_reg;
        irq_count_next   = irq_count_reg;
        irq_reload_next  = irq_reload_reg;
        irq_enable_next  = irq_enable_reg;
        irq_flag_next    = irq_flag_reg;
        reload_req_next  = reload_req_reg;
        if (issue)
        begin
            case (entry.kind)
                KIND_REG_WR:
                begin
                    case (entry.address[14:13])
                        WIN_SELECT:
                        begin
                            if (!entry.address[0])
                                bank_select_next = entry.write_data;
                            else
                                bank_regs_next[reg_num] = reg_data;
                        end
                        WIN_MIRROR:
                        begin
                            if (!entry.address[0])
                                mirror_next = entry.write_data[0] ? MIRROR_HORIZ : MIRROR_VERT;
                        end
                        WIN_RELOAD:
                        begin
                            if (!entry.address[0])
                                irq_reload_next = entry.write_data;
                            else
                                reload_req_next = 1'b1;
                        end
                        WIN_IRQ_EN:
                        begin
                            if (!entry.address[0])
                            begin
                                irq_enable_next = 1'b0;
                                irq_flag_next   = 1'b0;
                            end
                            else
                            begin
                                irq_enable_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            bank_select_next = bank_select_reg;
                        end
                    endcase
                end
                KIND_TICK:
                begin
                    if (reload_req_reg || irq_count_reg == 8'd0)
                    begin
                        reload_req_next = 1'b0;
                        irq_count_next  = irq_reload_reg;
                    end
                    else
                    begin
                        irq_count_next = irq_count_reg - 8'd1;
                    end
                    if (irq_count_next == 8'd0 && irq_enable_reg)
                        irq_flag_next = 1'b1;
                end
                KIND_ACK:
                begin
                    irq_flag_next = 1'b0;
                end
                default:
                begin
                    irq_flag_next = irq_flag_reg;
                end
            endcase
        end
    end

    // Result fields; read_data is filled in from the RAM in the execute stage.
    always_comb
    begin
        res.target       = TGT_PASS;
        res.mapped_addr  = 19'd0;
        res.chr_in_range = 1'b0;
        res.read_data    = 8'd0;
        res.irq_line     = irq_flag_next;
        res.mirror_mode  = mirror_next;
        case (entry.kind)
            KIND_PASS:
            begin
                res.mapped_addr = {3'd0, entry.address};
            end
            KIND_RAM_RD, KIND_RAM_WR:
            begin
                res.target      = TGT_RAM;
                res.mapped_addr = 19'(entry.address[RAM_AW-1:0]);
            end
            KIND_PRG_RD:
            begin
                res.target      = TGT_PRG;
                res.mapped_addr = {prg_bank, entry.address[12:0]};
            end
            KIND_REG_WR:
            begin
                res.target      = TGT_REG;
                res.mapped_addr = {3'd0, entry.address};
            end
            KIND_CHR:
            begin
                res.target       = TGT_CHR;
                res.mapped_addr  = chr_mapped;
                res.chr_in_range = (chr_mapped < {chr_count_reg, 10'd0});
            end
            default:
            begin
                res.target = TGT_PASS;
            end
        endcase
    end

    // The RAM byte joins the rest of the result on its way to the output register.
    always_comb
    begin
        s1_out           = s1_res_reg;
        s1_out.read_data = s1_ram_rd_reg ? ram_rdata : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_prg_reg    <= LAST_PRG_RESET;
            chr_count_reg   <= CHR_COUNT_RESET;
            bank_select_reg <= '0;
            for (int i = 0; i < BANK_REGS; i++)
                bank_regs_reg[i] <= '0;
            mirror_reg      <= MIRROR_HARD;
            irq_count_reg   <= '0;
            irq_reload_reg  <= '0;
            irq_enable_reg  <= 1'b0;
            irq_flag_reg    <= 1'b0;
            reload_req_reg  <= 1'b0;
            clearing_reg    <= 1'b1;
            clear_cnt_reg   <= '0;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                if (cfg_index == CFG_LAST_PRG)
                    last_prg_reg <= cfg_data[5:0];
                else
                    chr_count_reg <= cfg_data;
            end
            bank_select_reg <= bank_select_next;
            bank_regs_reg   <= bank_regs_next;
            mirror_reg      <= mirror_next;
            irq_count_reg   <= irq_count_next;
            irq_reload_reg  <= irq_reload_next;
            irq_enable_reg  <= irq_enable_next;
            irq_flag_reg    <= irq_flag_next;
            reload_req_reg  <= reload_req_next;
            if (clearing_reg)
            begin
                clear_cnt_reg <= clear_cnt_reg + 1'b1;
                if (clear_cnt_reg == RAM_AW'(WORK_RAM_BYTES - 1))
                    clearing_reg <= 1'b0;
            end
            if (issue)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            if (s1_adv)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_res_reg    <= res;
            s1_ram_rd_reg <= (entry.kind == KIND_RAM_RD);
        end
        if (s1_adv)
        begin
            out_reg <= s1_out;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

// ----- design/bank_switch_mapper_with_scanline_irq.sv -----
// Top level of the bank switching mapper with scanline IRQ counter.
// Depends on bsm_pkg, bsm_front, bsm_fifo, bsm_back and the assertion header.
//
//   Channel   Handshake                     Payload
//   item      item_valid / item_stall       item   (action, address, write_data)
//   result    result_valid / result_stall   result (target ... mirror_mode)
//   config    cfg_write_en                  cfg_index, cfg_data
//
// One item per cycle is sustained while no stall is raised; a result passes through the queue slot,
// the execute-stage register with the registered work RAM read, and the output register.
// After reset, item_stall stays high while the work RAM is cleared.
// A stalled result holds the execute stage; the two-entry queue then fills and raises
// item_stall.
`default_nettype none

`include "bank_switch_mapper_with_scanline_irq_assert.svh"

module bank_switch_mapper_with_scanline_irq (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire bsm_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output bsm_pkg::result_t      result,
    input  wire logic             cfg_write_en,
    input  wire logic             cfg_index,
    input  wire logic [8:0]       cfg_data
);
    import bsm_pkg::*;

    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_empty;
    logic   clearing;
    entry_t push_entry;
    entry_t head_entry;

    bsm_front u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .queue_full (q_full),
        .clearing   (clearing),
        .push       (q_push),
        .entry      (push_entry)
    );

    bsm_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head       (head_entry),
        .full       (q_full),
        .empty      (q_empty)
    );

    bsm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .entry        (head_entry),
        .queue_empty  (q_empty),
        .pop          (q_pop),
        .clearing     (clearing),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    `BSM_CHECK_IMP(a_no_push_when_full, q_push, !q_full, "push into a full queue")
    `BSM_CHECK_NEXT(a_push_lands, q_push, !q_empty, "pushed entry missing from queue")
    `BSM_CHECK_IMP(a_quiet_while_clearing, clearing, !result_valid && !q_pop,
                   "activity during the work RAM clearing pass")
    `BSM_CHECK_IMP(a_ram_offset_range, result_valid && result.target == TGT_RAM,
                   result.mapped_addr[18:RAM_AW] == '0, "work RAM offset out of range")

endmodule

`default_nettype wire
